// File: hw/rtl/kle_pkg.sv
// ----------------------------------------------------------------------------
// kle_pkg: shared constants for the keyword line value extractor
// Holds the keyword bytes, the control characters and the register defaults.
// ----------------------------------------------------------------------------
package kle_pkg;

   localparam int unsigned KEY_LEN = 9;
   localparam int unsigned POS_W   = 4;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CNT_W   = 8;

   // "Revision:"
   localparam logic [BYTE_W-1:0] KEYWORD [KEY_LEN] = '{
      8'h52, 8'h65, 8'h76, 8'h69, 8'h73, 8'h69, 8'h6F, 8'h6E, 8'h3A
   };

   localparam logic [POS_W-1:0]  KEY_LAST_POS = POS_W'(KEY_LEN - 1);

   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

   localparam logic [CNT_W-1:0]  CAPTURE_LIMIT_RESET = 8'd31;

   // tuser bit positions on the response side
   localparam int unsigned USER_CHAR_VALID = 0;
   localparam int unsigned USER_FOUND      = 1;
   localparam int unsigned USER_W          = 2;

endpackage : kle_pkg

// File: hw/rtl/keyword_line_value_extractor.sv
// ----------------------------------------------------------------------------
// keyword_line_value_extractor: pull the value of a "Revision:" line from text
// Matches the keyword at each line start, skips leading spaces and streams the
// value bytes out one per response, with found and last marks.
// ----------------------------------------------------------------------------
// Response: registered; it appears in the cycle after the request that causes it.
// Throughput: one request per cycle; the only stall is a held response
//    register (req_tready follows rsp_tready while a response waits).
// Reset: synchronous, active high; returns to line start matching with the
//    capture limit at 31 and no response pending.
module keyword_line_value_extractor (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [kle_pkg::BYTE_W-1:0]  req_tdata,   // [7:0] in_byte
   // response channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [kle_pkg::BYTE_W-1:0]  rsp_tdata,   // [7:0] out_char
   output logic [kle_pkg::USER_W-1:0]  rsp_tuser,   // [0] char_valid, [1] found
   output logic                        rsp_tlast,   // last
   // configuration
   input  logic                        csr_wr_en,
   input  logic [kle_pkg::CNT_W-1:0]   csr_wr_data  // capture_limit
);
   import kle_pkg::*;

   typedef enum logic [2:0] {
      PH_MATCH     = 3'd0,
      PH_SKIPLINE  = 3'd1,
      PH_SKIPSPACE = 3'd2,
      PH_CAPTURE   = 3'd3,
      PH_DONE      = 3'd4
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  limit_ff;

   logic              rsp_vld_ff;
   logic [BYTE_W-1:0] rsp_char_ff;
   logic              rsp_cvld_ff, rsp_found_ff, rsp_last_ff;

   logic              accept;
   logic              emit;
   logic [BYTE_W-1:0] emit_char;
   logic              emit_cvld, emit_found, emit_last;
   logic [BYTE_W-1:0] in_byte;
   logic [CNT_W-1:0]  cnt_inc;
   logic              is_term;

   // Take a new request whenever the response register is empty or draining.
   assign req_tready = !rsp_vld_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign in_byte    = req_tdata;

   assign cnt_inc = cnt_ff + CNT_W'(1);
   assign is_term = (in_byte == CH_CR) || (in_byte == CH_LF);

   // Next state and response for the byte on the request channel.
   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      cnt_in     = cnt_ff;
      emit       = 1'b0;
      emit_char  = CH_NUL;
      emit_cvld  = 1'b0;
      emit_found = 1'b0;
      emit_last  = 1'b0;

      if (in_byte == CH_NUL) begin
         // End of message: report the outcome unless it was already reported.
         emit       = (phase_ff != PH_DONE);
         emit_found = (phase_ff == PH_SKIPSPACE) || (phase_ff == PH_CAPTURE);
         emit_last  = 1'b1;
         phase_in   = PH_MATCH;
         pos_in     = '0;
         cnt_in     = '0;
      end else begin
         unique case (phase_ff)
            PH_MATCH: begin
               if (pos_ff <= KEY_LAST_POS && in_byte == KEYWORD[pos_ff]) begin
                  if (pos_ff == KEY_LAST_POS) begin
                     pos_in = '0;
                     cnt_in = '0;
                     if (limit_ff == '0) begin
                        // Nothing may be captured: finish right on the colon.
                        emit       = 1'b1;
                        emit_found = 1'b1;
                        emit_last  = 1'b1;
                        phase_in   = PH_DONE;
                     end else begin
                        phase_in = PH_SKIPSPACE;
                     end
                  end else begin
                     pos_in = pos_ff + POS_W'(1);
                  end
               end else begin
                  pos_in   = '0;
                  phase_in = (in_byte == CH_LF) ? PH_MATCH : PH_SKIPLINE;
               end
            end
            PH_SKIPLINE: begin
               if (in_byte == CH_LF) begin
                  phase_in = PH_MATCH;
                  pos_in   = '0;
               end
            end
            PH_SKIPSPACE, PH_CAPTURE: begin
               if (!(phase_ff == PH_SKIPSPACE && in_byte == CH_SPACE)) begin
                  emit       = 1'b1;
                  emit_found = 1'b1;
                  if (is_term || cnt_ff >= limit_ff) begin
                     // Line ended or limit already used up: close without a char.
                     emit_last = 1'b1;
                     phase_in  = PH_DONE;
                  end else begin
                     cnt_in    = cnt_inc;
                     emit_char = in_byte;
                     emit_cvld = 1'b1;
                     emit_last = (cnt_inc >= limit_ff);
                     phase_in  = emit_last ? PH_DONE : PH_CAPTURE;
                  end
               end
            end
            default: begin
               // Done: drop bytes until the message ends.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MATCH;
         pos_ff     <= '0;
         cnt_ff     <= '0;
         limit_ff   <= CAPTURE_LIMIT_RESET;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            cnt_ff   <= cnt_in;
         end
         // Load a new response, or clear the register once it is taken.
         if (accept && emit) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // Response payload: no reset needed, qualified by rsp_vld_ff.
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_char_ff  <= emit_char;
         rsp_cvld_ff  <= emit_cvld;
         rsp_found_ff <= emit_found;
         rsp_last_ff  <= emit_last;
      end
   end

   assign rsp_tvalid                 = rsp_vld_ff;
   assign rsp_tdata                  = rsp_char_ff;
   assign rsp_tuser[USER_CHAR_VALID] = rsp_cvld_ff;
   assign rsp_tuser[USER_FOUND]      = rsp_found_ff;
   assign rsp_tlast                  = rsp_last_ff;

   // A captured character only ever comes after a keyword match.
   a_char_implies_found: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (!rsp_cvld_ff || rsp_found_ff))
      else $error("char_valid response without found");

   // Once the final response is out, nothing more until the message ends.
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_DONE) |-> !emit)
      else $error("response emitted after the final one");

   // The end-of-message byte always brings the scanner back to line start.
   a_nul_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && in_byte == CH_NUL) |=> (phase_ff == PH_MATCH && pos_ff == '0 && cnt_ff == '0))
      else $error("end of message did not restart matching");

   // The match position never runs past the keyword.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= KEY_LAST_POS)
      else $error("match position out of range");

endmodule : keyword_line_value_extractor

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for keyword_line_value_extractor
// Drives text messages byte by byte and checks every response against a
// predictor of the keyword scan. A short directed table comes first, then
// random messages under changing capture limits. Random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
   import kle_pkg::*;

   // watchdog: cycles with no handshake on either side before giving up
   localparam int unsigned HANG_LIMIT   = 1000;
   // random part starts no new phase once this many requests have gone in
   localparam int unsigned SCAN_TARGET  = 1700;
   localparam int unsigned PHASE_BYTES  = 150;
   localparam int unsigned REPORT_LINES = 100;

   typedef enum logic [2:0] {
      SCAN_MATCH,
      SCAN_SKIP_LINE,
      SCAN_SKIP_SPACE,
      SCAN_CAPTURE,
      SCAN_DONE
   } scan_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] ch;
      logic              char_valid;
      logic              found;
      logic              last;
   } value_rsp_type;

   typedef struct packed {
      logic [BYTE_W-1:0] text;
      logic              typed;
      value_rsp_type     want;
   } directed_row_type;

   localparam value_rsp_type NO_RSP     = '0;
   localparam value_rsp_type NOT_FOUND  =
      '{ch: 8'h00, char_valid: 1'b0, found: 1'b0, last: 1'b1};
   localparam value_rsp_type LINE_ENDED =
      '{ch: 8'h00, char_valid: 1'b0, found: 1'b1, last: 1'b1};

   // Directed opening: zero byte right after reset, a stray line closed by a
   // line feed, a full keyword line with leading spaces ended by a carriage
   // return, ignored bytes after the final response, then a broken keyword.
   localparam int unsigned INTRO_ROWS = 22;
   localparam directed_row_type INTRO [INTRO_ROWS] = '{
      '{8'h00, 1'b1, NOT_FOUND},
      '{8'hFF, 1'b0, NO_RSP},
      '{8'h0A, 1'b0, NO_RSP},
      '{"R",   1'b0, NO_RSP},
      '{"e",   1'b0, NO_RSP},
      '{"v",   1'b0, NO_RSP},
      '{"i",   1'b0, NO_RSP},
      '{"s",   1'b0, NO_RSP},
      '{"i",   1'b0, NO_RSP},
      '{"o",   1'b0, NO_RSP},
      '{"n",   1'b0, NO_RSP},
      '{":",   1'b0, NO_RSP},
      '{8'h20, 1'b0, NO_RSP},
      '{8'h20, 1'b0, NO_RSP},
      '{8'h01, 1'b0, NO_RSP},
      '{8'h0D, 1'b1, LINE_ENDED},
      '{8'h41, 1'b0, NO_RSP},
      '{8'h00, 1'b0, NO_RSP},
      '{"R",   1'b0, NO_RSP},
      '{"e",   1'b0, NO_RSP},
      '{"x",   1'b0, NO_RSP},
      '{8'h00, 1'b1, NOT_FOUND}
   };

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [BYTE_W-1:0]   req_tdata   = '0;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [BYTE_W-1:0]   rsp_tdata;
   logic [USER_W-1:0]   rsp_tuser;
   logic                rsp_tlast;
   logic                csr_wr_en   = 1'b0;
   logic [CNT_W-1:0]    csr_wr_data = '0;

   // predictor state, mirrors the block's scan
   scan_state_type      scan_state  = SCAN_MATCH;
   logic [POS_W-1:0]    key_pos     = '0;
   logic [CNT_W-1:0]    value_count = '0;
   logic [CNT_W-1:0]    value_limit = CAPTURE_LIMIT_RESET;

   value_rsp_type       expected_values [$];
   int unsigned         mismatches  = 0;
   int unsigned         scanned     = 0;
   bit                  req_steady  = 1'b0;
   bit                  rsp_steady  = 1'b0;

   keyword_line_value_extractor uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      if (mismatches < REPORT_LINES) begin
         $display("tb: mismatch at %0t: %s", $realtime, what);
      end
      mismatches++;
   endtask

   // Advance the scan by one byte; return 1 with the response it causes.
   function automatic bit scan_byte(input logic [BYTE_W-1:0] b, output value_rsp_type r);
      bit emit;
      emit = 1'b0;
      r    = '0;
      if (b == CH_NUL) begin
         if (scan_state == SCAN_MATCH || scan_state == SCAN_SKIP_LINE) begin
            r.last = 1'b1;
            emit   = 1'b1;
         end else if (scan_state == SCAN_SKIP_SPACE || scan_state == SCAN_CAPTURE) begin
            r.found = 1'b1;
            r.last  = 1'b1;
            emit    = 1'b1;
         end
         scan_state  = SCAN_MATCH;
         key_pos     = '0;
         value_count = '0;
         return emit;
      end
      case (scan_state)
         SCAN_MATCH: begin
            if (b == KEYWORD[key_pos]) begin
               if (key_pos == KEY_LAST_POS) begin
                  key_pos     = '0;
                  value_count = '0;
                  if (value_limit == '0) begin
                     r.found    = 1'b1;
                     r.last     = 1'b1;
                     emit       = 1'b1;
                     scan_state = SCAN_DONE;
                  end else begin
                     scan_state = SCAN_SKIP_SPACE;
                  end
               end else begin
                  key_pos = key_pos + 1'b1;
               end
            end else begin
               key_pos    = '0;
               scan_state = (b == CH_LF) ? SCAN_MATCH : SCAN_SKIP_LINE;
            end
         end
         SCAN_SKIP_LINE: begin
            if (b == CH_LF) begin
               scan_state = SCAN_MATCH;
               key_pos    = '0;
            end
         end
         SCAN_SKIP_SPACE, SCAN_CAPTURE: begin
            if (!(scan_state == SCAN_SKIP_SPACE && b == CH_SPACE)) begin
               emit    = 1'b1;
               r.found = 1'b1;
               // line end, or limit already met after a lowered limit
               if (b == CH_CR || b == CH_LF || value_count >= value_limit) begin
                  r.last     = 1'b1;
                  scan_state = SCAN_DONE;
               end else begin
                  value_count  = value_count + 1'b1;
                  r.ch         = b;
                  r.char_valid = 1'b1;
                  r.last       = (value_count >= value_limit);
                  scan_state   = r.last ? SCAN_DONE : SCAN_CAPTURE;
               end
            end
         end
         default: ;
      endcase
      return emit;
   endfunction

   // Send one request byte after a random gap and hold it until taken.
   // Called on a rising edge; returns on the edge of the handshake.
   task automatic push_request(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                               input value_rsp_type want = '0);
      int unsigned   gap;
      value_rsp_type r;
      bit            emit;
      if ($urandom_range(0, 39) == 0) begin
         req_steady = !req_steady;
      end
      gap = req_steady ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      scanned++;
      emit = scan_byte(b, r);
      if (typed) begin
         expected_values.push_back(want);
      end else if (emit) begin
         expected_values.push_back(r);
      end
   endtask

   // Write the capture limit once every response is in and the block is quiet.
   task automatic set_capture_limit(input logic [CNT_W-1:0] v);
      req_tvalid <= 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      value_limit  = v;
   endtask

   function automatic logic [BYTE_W-1:0] any_char();
      return BYTE_W'($urandom_range(1, 255));
   endfunction

   // Keyword line, possibly with one byte broken, then leading spaces.
   task automatic push_keyword(input int unsigned broken_at);
      for (int unsigned i = 0; i < KEY_LEN; i++) begin
         push_request((i == broken_at) ? any_char() : KEYWORD[i]);
      end
      repeat ($urandom_range(0, 3)) push_request(CH_SPACE);
   endtask

   // One message: mostly well-formed with random content, some pure noise.
   task automatic push_message();
      int unsigned len;
      int unsigned cut;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(0, 20)) push_request(any_char());
         push_request(CH_NUL);
         return;
      end
      // lines ahead of the keyword: partial keywords and plain text
      repeat ($urandom_range(0, 2)) begin
         cut = $urandom_range(0, KEY_LEN - 1);
         for (int unsigned i = 0; i < cut; i++) begin
            push_request(KEYWORD[i]);
         end
         repeat ($urandom_range(0, 6)) push_request(any_char());
         push_request(CH_LF);
      end
      push_keyword(($urandom_range(0, 7) == 0) ? $urandom_range(0, KEY_LEN - 1) : KEY_LEN);
      if (value_limit == 8'd255 && $urandom_range(0, 3) == 0) begin
         len = $urandom_range(200, 270);
      end else begin
         len = $urandom_range(0, (value_limit > 12) ? 14 : value_limit + 2);
      end
      repeat (len) push_request(any_char());
      case ($urandom_range(0, 3))
         0: push_request(CH_CR);
         1: push_request(CH_LF);
         default: ;
      endcase
      repeat ($urandom_range(0, 4)) push_request(any_char());
      push_request(CH_NUL);
   endtask

   // response side: random stall per response, check each against the oldest
   initial begin : rsp_check
      int unsigned   stall;
      value_rsp_type want;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) begin
            rsp_steady = !rsp_steady;
         end
         stall = rsp_steady ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (expected_values.size() == 0) begin
            report_mismatch($sformatf("response %h with none expected", rsp_tdata));
         end else begin
            want = expected_values.pop_front();
            if (rsp_tdata !== want.ch) begin
               report_mismatch($sformatf("out_char %h, want %h", rsp_tdata, want.ch));
            end
            if (rsp_tuser[USER_CHAR_VALID] !== want.char_valid) begin
               report_mismatch($sformatf("char_valid %b, want %b",
                                         rsp_tuser[USER_CHAR_VALID], want.char_valid));
            end
            if (rsp_tuser[USER_FOUND] !== want.found) begin
               report_mismatch($sformatf("found %b, want %b",
                                         rsp_tuser[USER_FOUND], want.found));
            end
            if (rsp_tlast !== want.last) begin
               report_mismatch($sformatf("last %b, want %b", rsp_tlast, want.last));
            end
         end
      end
   end

   // hang detection: count edges with no handshake on either side
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < HANG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("tb: done, errors");
      $finish;
   end

   initial begin : stimulus
      int unsigned phase_end;
      int unsigned phase_no;
      logic [CNT_W-1:0] next_limit;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at the reset limit
      for (int unsigned i = 0; i < INTRO_ROWS; i++) begin
         push_request(INTRO[i].text, INTRO[i].typed, INTRO[i].want);
      end

      // random phases, each under its own capture limit
      phase_no = 0;
      while (scanned < SCAN_TARGET) begin
         case (phase_no)
            0: next_limit = 8'd0;
            1: next_limit = 8'd255;
            2: next_limit = 8'd1;
            default: begin
               case ($urandom_range(0, 4))
                  0: next_limit = CNT_W'($urandom_range(0, 255));
                  1: next_limit = CNT_W'($urandom_range(1, 8));
                  2: next_limit = CAPTURE_LIMIT_RESET;
                  3: next_limit = 8'd0;
                  default: next_limit = CNT_W'($urandom_range(2, 20));
               endcase
            end
         endcase
         set_capture_limit(next_limit);
         phase_end = scanned + PHASE_BYTES;
         while (scanned < phase_end) begin
            push_message();
         end
         // leave half the phases mid-capture so the new limit lands inside a value
         if ($urandom_range(0, 1) == 0) begin
            push_keyword(KEY_LEN);
            repeat ($urandom_range(0, 5)) push_request(any_char());
         end
         phase_no++;
      end

      // drain: release the request side and wait out every response
      req_tvalid <= 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
